// File: hdl/lzwbse_pkg.sv
// ----------------------------------------------------------------------------
// lzwbse_pkg
// Shared types and constants of the LZW byte stream encoder.
// ----------------------------------------------------------------------------
package lzwbse_pkg;

	localparam int DictEntriesDefault = 4096;
	localparam int SymW               = 8;
	localparam int AlphaW             = 9;
	localparam int MaxBytes           = 4;
	localparam logic [AlphaW-1:0] AlphaMin   = 9'd2;
	localparam logic [AlphaW-1:0] AlphaMax   = 9'd256;
	localparam logic [AlphaW-1:0] AlphaReset = 9'd256;

	// One queued input item as seen by the back end.
	typedef struct packed {
		logic            valid;
		logic [SymW-1:0] symbol;
		logic            last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_FIN,
		ST_EMIT
	} eng_state_t;

endpackage

// File: hdl/lzwbse_ram.sv
// ----------------------------------------------------------------------------
// lzwbse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwbse_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/lzwbse_front.sv
// ----------------------------------------------------------------------------
// lzwbse_front
// Input side: takes symbol transfers into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lzwbse_front
	import lzwbse_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [SymW-1:0] symbol,
	input  logic            last_symbol,
	output item_t           item,
	input  logic            pop
);

	logic [SymW:0] slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          take;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign take     = pop && (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= {last_symbol, symbol};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, take};
		end
	end

	always_comb begin
		item.valid  = (count_q != 2'd0);
		item.symbol = slot_q[rd_ptr_q][SymW-1:0];
		item.last   = slot_q[rd_ptr_q][SymW];
	end

endmodule

// File: hdl/lzwbse_engine.sv
// ----------------------------------------------------------------------------
// lzwbse_engine
// Back end: dictionary search, entry insertion and code byte output.
// ----------------------------------------------------------------------------
module lzwbse_engine
	import lzwbse_pkg::*;
#(
	parameter int DictEntries = DictEntriesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [AlphaW-1:0] cfg_wdata,
	input  item_t             item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        code_byte,
	output logic              last_byte
);

	localparam int AW = $clog2(DictEntries);
	localparam int EW = AW + SymW;

	eng_state_t state_q, state_n;

	logic [AlphaW-1:0] alpha_q;
	logic [AW-1:0]     next_free_q, next_free_n;
	logic [AW-1:0]     prefix_q, prefix_n;
	logic              pvalid_q, pvalid_n;
	logic [SymW-1:0]   sym_q;
	logic              last_q;
	logic [AW-1:0]     scan_q, scan_n;
	logic [7:0]        buf_q [MaxBytes];
	logic [7:0]        buf_n [MaxBytes];
	logic [2:0]        cnt_q, cnt_n;
	logic [1:0]        rd_q, rd_n;

	logic              out_valid_q;
	logic [7:0]        code_byte_q;
	logic              last_byte_q;
	logic              out_free;
	logic              out_load;

	logic              ram_we;
	logic              ram_re;
	logic [EW-1:0]     ram_rdata;
	logic [AW-1:0]     alpha_aw;
	logic [AW-1:0]     nf_inc;
	logic              scan_end;
	logic              hit;
	logic [AlphaW-1:0] alpha_sat;

	assign alpha_aw = AW'(alpha_q);
	assign nf_inc   = (({1'b0, next_free_q} + 1'b1) == (AW+1)'(DictEntries))
		? alpha_aw : next_free_q + 1'b1;
	assign scan_end = (scan_q >= next_free_q);
	assign hit      = (ram_rdata == {prefix_q, sym_q});
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_EMIT) && out_free;

	always_comb begin
		if (cfg_wdata < AlphaMin) alpha_sat = AlphaMin;
		else if (cfg_wdata > AlphaMax) alpha_sat = AlphaMax;
		else alpha_sat = cfg_wdata;
	end

	lzwbse_ram #(
		.Width(EW),
		.Depth(DictEntries)
	) u_dict (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(next_free_q),
		.wr_data({prefix_q, sym_q}),
		.rd_en  (ram_re),
		.rd_addr(scan_q),
		.rd_data(ram_rdata)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item.valid) state_n = pvalid_q ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: state_n = scan_end ? ST_FIN : ST_CMP;
			ST_CMP:  state_n = hit ? ST_FIN : ST_SCAN;
			ST_FIN: begin
				if (last_q || cnt_q != 3'd0) state_n = ST_EMIT;
				else state_n = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free && ({1'b0, rd_q} + 3'd1 == cnt_q)) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Datapath and control outputs.
	always_comb begin
		logic wide;
		logic [15:0] c16;
		wide        = 1'b0;
		c16         = '0;
		pop         = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		next_free_n = next_free_q;
		prefix_n    = prefix_q;
		pvalid_n    = pvalid_q;
		scan_n      = scan_q;
		cnt_n       = cnt_q;
		rd_n        = rd_q;
		for (int k = 0; k < MaxBytes; k++) buf_n[k] = buf_q[k];
		case (state_q)
			ST_IDLE: begin
				pop   = item.valid;
				cnt_n = 3'd0;
				rd_n  = 2'd0;
				scan_n = alpha_aw;
				if (item.valid && !pvalid_q) begin
					prefix_n = AW'(item.symbol);
					pvalid_n = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					// Miss: send the prefix code, add the extension, restart.
					wide = |next_free_q[AW-1:8];
					c16  = 16'(prefix_q);
					if (wide) begin
						buf_n[0] = c16[15:8];
						buf_n[1] = c16[7:0];
						cnt_n    = 3'd2;
					end else begin
						buf_n[0] = c16[7:0];
						cnt_n    = 3'd1;
					end
					ram_we      = 1'b1;
					next_free_n = nf_inc;
					prefix_n    = AW'(sym_q);
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_CMP: begin
				if (hit) prefix_n = scan_q;
				else scan_n = scan_q + 1'b1;
			end
			ST_FIN: begin
				if (last_q) begin
					// Final symbol flushes the pending prefix and starts a new image.
					wide = |next_free_q[AW-1:8];
					c16  = 16'(prefix_q);
					if (wide) begin
						buf_n[cnt_q[1:0]]        = c16[15:8];
						buf_n[cnt_q[1:0] + 2'd1] = c16[7:0];
						cnt_n = cnt_q + 3'd2;
					end else begin
						buf_n[cnt_q[1:0]] = c16[7:0];
						cnt_n = cnt_q + 3'd1;
					end
					next_free_n = alpha_aw;
					prefix_n    = '0;
					pvalid_n    = 1'b0;
				end
			end
			ST_EMIT: begin
				if (out_free) rd_n = rd_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			sym_q  <= item.symbol;
			last_q <= item.last;
		end
		for (int k = 0; k < MaxBytes; k++) buf_q[k] <= buf_n[k];
		if (out_load) begin
			code_byte_q <= buf_q[rd_q];
			last_byte_q <= ({1'b0, rd_q} + 3'd1 == cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alpha_q     <= AlphaReset;
			next_free_q <= AW'(AlphaReset);
			prefix_q    <= '0;
			pvalid_q    <= 1'b0;
			scan_q      <= '0;
			cnt_q       <= 3'd0;
			rd_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			scan_q   <= scan_n;
			cnt_q    <= cnt_n;
			rd_q     <= rd_n;
			if (cfg_we) begin
				alpha_q     <= alpha_sat;
				next_free_q <= AW'(alpha_sat);
				prefix_q    <= '0;
				pvalid_q    <= 1'b0;
			end else begin
				next_free_q <= next_free_n;
				prefix_q    <= prefix_n;
				pvalid_q    <= pvalid_n;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = code_byte_q;
	assign last_byte = last_byte_q;

endmodule

// File: hdl/lzw_byte_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzw_byte_stream_encoder_unit
// LZW encoder over palette-index symbols producing a byte stream of codes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  symbol[7:0], last_symbol
// output    out        out_valid / out_stall code_byte[7:0], last_byte
// config    in         cfg_we               cfg_wdata[8:0] (alphabet size)
//
// Each dictionary entry searched takes a read state, then a compare state (one
// port of the dictionary RAM), from alphabet_size up to the next free entry;
// the finish state follows a hit or a miss, and the emit state sends one byte
// per cycle while the output is not stalled.
// Reset clears all control state; the dictionary RAM is not cleared, since
// only entries written since the last restart are ever searched.
// A two-entry input queue takes transfers while the engine searches, until full.
// While the output is stalled the engine waits until each byte of a step has
// been loaded into the output register; the register then holds the final
// byte while the engine moves on to the next symbol.
// ----------------------------------------------------------------------------
module lzw_byte_stream_encoder_unit
	import lzwbse_pkg::*;
#(
	parameter int DictEntries = DictEntriesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [AlphaW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SymW-1:0]   symbol,
	input  logic              last_symbol,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        code_byte,
	output logic              last_byte
);

	item_t item;
	logic  pop;

	// Front end: queues symbol transfers for the engine.
	lzwbse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.last_symbol(last_symbol),
		.item       (item),
		.pop        (pop)
	);

	// Back end: searches the dictionary, adds entries and sends code bytes.
	lzwbse_engine #(
		.DictEntries(DictEntries)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.last_byte(last_byte)
	);

endmodule

// File: hdl/lzwbse_checker.sv
// ----------------------------------------------------------------------------
// lzwbse_checker
// Port-level checks of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lzwbse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] code_byte,
	input logic       last_byte,
	input logic       in_stall
);

	// A stalled byte holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_byte) && $stable(last_byte))
	else $error("stalled output byte changed");

	// Bytes of one code sequence follow without gaps.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_valid)
	else $error("gap inside a code byte sequence");

	// The queue is empty after reset, so the first cycle accepts input.
	assert property (@(posedge clk) $rose(arst_n) |-> !in_stall)
	else $error("input stalled right after reset");

endmodule

bind lzw_byte_stream_encoder_unit lzwbse_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.code_byte(code_byte),
	.last_byte(last_byte),
	.in_stall (in_stall)
);
